// File: sv/hid_report_fragmenter_assert.svh
// Assertion macros shared by the HID report fragmenter RTL.
`ifndef HID_REPORT_FRAGMENTER_ASSERT_SVH
`define HID_REPORT_FRAGMENTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define HRF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/hrf_pkg.sv
// Types and constants of the HID report fragmenter.
`default_nettype none

package hrf_pkg;

    localparam int NUM_REPORTS = 6;

    localparam logic [23:0] ENTRY_RESET = 24'h010040;

    // Configuration register indexes
    localparam logic [2:0] CFG_IDX_ENTRY_0 = 3'd0;
    localparam logic [2:0] CFG_IDX_ENTRIES = 3'd6;

    // Link byte codes
    localparam logic [7:0] LINK_SINGLE = 8'h00;
    localparam logic [7:0] LINK_LAST   = 8'h01;
    localparam logic [7:0] LINK_FIRST  = 8'h02;
    localparam logic [7:0] LINK_MIDDLE = 8'h03;

    typedef struct packed {
        logic [7:0]  cmd_byte;
        logic [15:0] msg_length;
        logic        first_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_report;
        logic       last;
    } t_out_item;

endpackage

`default_nettype wire

// File: sv/hid_report_fragmenter.sv
// HID report fragmenter: splits a byte-wise command message into HID reports.
// An accepted byte is held in the input register, then its results are written into the
// result queue, from which they are offered at the output.
// Throughput: one input byte per cycle while the output keeps up; a report start queues
// an id, a link and a payload byte and holds off the next byte until at most one result is queued.
// Reset (synchronous, active low) empties the stage and queue, clears the message state
// and restores every table entry to id 1, size 64, with one entry in use.
`default_nettype none

`include "hid_report_fragmenter_assert.svh"

module hid_report_fragmenter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire hrf_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output hrf_pkg::t_out_item     o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [23:0]       i_cfg_data
);

    localparam int QDEPTH = 4;

    // configuration
    logic [23:0] r_entry [hrf_pkg::NUM_REPORTS];
    logic [2:0]  r_entries_in_use;

    // input register
    logic              r_in_valid;
    hrf_pkg::t_in_item r_in;

    // message state
    logic [15:0] r_bytes_done;
    logic [15:0] r_payload_left;
    logic        r_first_report_done;

    // result queue
    hrf_pkg::t_out_item r_q [QDEPTH];
    logic [1:0]         r_wr_ptr;
    logic [1:0]         r_rd_ptr;
    logic [2:0]         r_count;

    logic        proc;
    logic        pop;
    logic [1:0]  push_cnt;
    logic [15:0] eff_bd;
    logic [15:0] eff_pl;
    logic        eff_frd;
    logic        start;
    logic [15:0] remaining;
    logic [16:0] need;
    logic [2:0]  n_active;
    logic [23:0] sel_entry;
    logic [15:0] sel_size;
    logic [15:0] cap;
    logic        final_rep;
    logic [7:0]  link;
    logic [15:0] n_payload_left;
    logic [15:0] n_bytes_done;
    logic        n_first_report_done;
    hrf_pkg::t_out_item res_id;
    hrf_pkg::t_out_item res_link;
    hrf_pkg::t_out_item res_pay;

    assign o_cfg_ready = 1'b1;

    // Move the staged byte into the queue only when three slots are surely free.
    assign proc        = r_in_valid && (r_count <= 3'd1);
    assign o_in_ready  = !r_in_valid || proc;
    assign o_out_valid = (r_count != 3'd0);
    assign o_out_data  = r_q[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        eff_bd  = r_in.first_of_message ? 16'd0 : r_bytes_done;
        eff_pl  = r_in.first_of_message ? 16'd0 : r_payload_left;
        eff_frd = r_in.first_of_message ? 1'b0 : r_first_report_done;
        start   = (eff_pl == 16'd0);

        remaining = (r_in.msg_length > eff_bd) ? (r_in.msg_length - eff_bd) : 16'd1;
        need      = {1'b0, remaining} + 17'd2;

        if (r_entries_in_use == 3'd0) begin
            n_active = 3'd1;
        end else if (r_entries_in_use > 3'(hrf_pkg::NUM_REPORTS)) begin
            n_active = 3'(hrf_pkg::NUM_REPORTS);
        end else begin
            n_active = r_entries_in_use;
        end

        // Fallback is the last entry in use; the lowest fitting index wins.
        sel_entry = r_entry[3'(n_active - 3'd1)];
        for (int i = hrf_pkg::NUM_REPORTS - 1; i >= 0; i--) begin
            if ((3'(i) < n_active) && ({1'b0, r_entry[i][15:0]} >= need)) begin
                sel_entry = r_entry[i];
            end
        end
        sel_size = sel_entry[15:0];

        cap       = (sel_size >= 16'd3) ? (sel_size - 16'd2) : 16'd1;
        final_rep = (remaining <= cap);

        if (final_rep) begin
            link = eff_frd ? hrf_pkg::LINK_LAST : hrf_pkg::LINK_SINGLE;
        end else begin
            link = eff_frd ? hrf_pkg::LINK_MIDDLE : hrf_pkg::LINK_FIRST;
        end

        n_payload_left      = (start ? (final_rep ? remaining : cap) : eff_pl) - 16'd1;
        n_first_report_done = start ? 1'b1 : eff_frd;
        n_bytes_done        = (eff_bd == 16'hFFFF) ? eff_bd : (eff_bd + 16'd1);

        res_id.out_byte        = sel_entry[23:16];
        res_id.end_of_report   = 1'b0;
        res_id.last            = 1'b0;
        res_link.out_byte      = link;
        res_link.end_of_report = 1'b0;
        res_link.last          = 1'b0;
        res_pay.out_byte       = r_in.cmd_byte;
        res_pay.end_of_report  = (n_payload_left == 16'd0);
        res_pay.last           = 1'b1;

        push_cnt = start ? 2'd3 : 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hrf_pkg::NUM_REPORTS; i++) begin
                r_entry[i] <= hrf_pkg::ENTRY_RESET;
            end
            r_entries_in_use    <= 3'd1;
            r_in_valid          <= 1'b0;
            r_bytes_done        <= 16'd0;
            r_payload_left      <= 16'd0;
            r_first_report_done <= 1'b0;
            r_wr_ptr            <= 2'd0;
            r_rd_ptr            <= 2'd0;
            r_count             <= 3'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == hrf_pkg::CFG_IDX_ENTRIES) begin
                    r_entries_in_use <= i_cfg_data[2:0];
                end else if ((i_cfg_index - hrf_pkg::CFG_IDX_ENTRY_0)
                             < 3'(hrf_pkg::NUM_REPORTS)) begin
                    r_entry[i_cfg_index] <= i_cfg_data;
                end
            end

            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            if (proc) begin
                r_bytes_done        <= n_bytes_done;
                r_payload_left      <= n_payload_left;
                r_first_report_done <= n_first_report_done;
                r_wr_ptr            <= r_wr_ptr + push_cnt;
            end

            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end

            r_count <= r_count + (proc ? {1'b0, push_cnt} : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    // Payload registers: input stage and queue entries.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (proc) begin
            if (start) begin
                r_q[r_wr_ptr]         <= res_id;
                r_q[r_wr_ptr + 2'd1]  <= res_link;
                r_q[r_wr_ptr + 2'd2]  <= res_pay;
            end else begin
                r_q[r_wr_ptr]         <= res_pay;
            end
        end
    end

    `HRF_ASSERT_IMP(a_queue_room, proc, r_count <= 3'd1, "queue overfilled by a transaction")
    `HRF_ASSERT_IMP(a_count_bound, 1'b1, r_count <= 3'(QDEPTH), "queue count out of range")
    `HRF_ASSERT_NXT(a_start_three, proc && start && !pop,
                    r_count == $past(r_count) + 3'd3, "report start did not queue three results")
    `HRF_ASSERT_IMP(a_left_needs_start, r_payload_left != 16'd0, r_first_report_done,
                    "payload pending without a started report")
    `HRF_ASSERT_NXT(a_pop_only, !proc && pop, r_count == $past(r_count) - 3'd1,
                    "queue count lost track of a drained result")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the HID report fragmenter: directed and random messages.
module testbench;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    hrf_pkg::t_in_item  in_data = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [23:0]        cfg_data = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    hrf_pkg::t_out_item o_out_data;
    logic               o_cfg_ready;

    // Predicted block state and its copy of the report table
    logic [23:0] rpt_table [hrf_pkg::NUM_REPORTS];
    logic [2:0]  rpt_count;
    logic [15:0] bytes_taken;
    logic [15:0] payload_due;
    logic        msg_started;

    hrf_pkg::t_out_item expected_report_bytes [$];
    logic [23:0] cfg_table [hrf_pkg::NUM_REPORTS];
    logic [2:0]  cfg_count;
    int          in_idle_pct = 0;
    int          out_stall_pct = 0;
    int          bytes_sent = 0;
    int          mismatch_cnt = 0;

    hid_report_fragmenter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    function automatic logic [23:0] choose_entry(input int need);
        int n;
        n = rpt_count;
        if (n == 0) n = 1;
        if (n > hrf_pkg::NUM_REPORTS) n = hrf_pkg::NUM_REPORTS;
        for (int i = 0; i < n; i++) begin
            if (int'(rpt_table[i][15:0]) >= need) return rpt_table[i];
        end
        return rpt_table[n - 1];
    endfunction

    function automatic void fragment_byte(input hrf_pkg::t_in_item item);
        int          remaining;
        int          cap;
        logic [23:0] entry;
        logic [7:0]  link;
        logic        final_rep;
        if (item.first_of_message) begin
            bytes_taken = '0;
            payload_due = '0;
            msg_started = 1'b0;
        end
        if (payload_due == 16'd0) begin
            remaining = (item.msg_length > bytes_taken) ? int'(item.msg_length - bytes_taken) : 1;
            entry = choose_entry(remaining + 2);
            cap = (entry[15:0] >= 16'd3) ? int'(entry[15:0]) - 2 : 1;
            final_rep = (remaining <= cap);
            if (final_rep) link = msg_started ? hrf_pkg::LINK_LAST : hrf_pkg::LINK_SINGLE;
            else link = msg_started ? hrf_pkg::LINK_MIDDLE : hrf_pkg::LINK_FIRST;
            expected_report_bytes.push_back('{out_byte: entry[23:16], end_of_report: 1'b0,
                                              last: 1'b0});
            expected_report_bytes.push_back('{out_byte: link, end_of_report: 1'b0, last: 1'b0});
            payload_due = final_rep ? 16'(remaining) : 16'(cap);
            msg_started = 1'b1;
        end
        payload_due = payload_due - 16'd1;
        if (bytes_taken != 16'hFFFF) bytes_taken = bytes_taken + 16'd1;
        expected_report_bytes.push_back('{out_byte: item.cmd_byte,
                                          end_of_report: (payload_due == 16'd0), last: 1'b1});
    endfunction

    // Compare every output transaction with the oldest prediction
    always @(posedge i_clk) begin
        hrf_pkg::t_out_item exp_res;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_report_bytes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_out_data);
                mismatch_cnt++;
            end else begin
                exp_res = expected_report_bytes.pop_front();
                if (o_out_data.out_byte !== exp_res.out_byte) begin
                    $display("%0t: out_byte expected %h actual %h", $time,
                             exp_res.out_byte, o_out_data.out_byte);
                    mismatch_cnt++;
                end
                if (o_out_data.end_of_report !== exp_res.end_of_report) begin
                    $display("%0t: end_of_report expected %b actual %b", $time,
                             exp_res.end_of_report, o_out_data.end_of_report);
                    mismatch_cnt++;
                end
                if (o_out_data.last !== exp_res.last) begin
                    $display("%0t: last expected %b actual %b", $time,
                             exp_res.last, o_out_data.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Leave valid high on return; the next caller holds or drops it
    task automatic send_byte(input hrf_pkg::t_in_item item);
        if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        fragment_byte(item);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(input logic [15:0] len, input int nbytes, input bit mark,
                                input bit jitter);
        hrf_pkg::t_in_item item;
        for (int i = 0; i < nbytes; i++) begin
            item.cmd_byte = 8'($urandom);
            item.msg_length = (jitter && i > 0) ? 16'($urandom) : len;
            item.first_of_message = mark && (i == 0);
            send_byte(item);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < hrf_pkg::CFG_IDX_ENTRIES) rpt_table[idx] = data;
        else if (idx == hrf_pkg::CFG_IDX_ENTRIES) rpt_count = data[2:0];
        @(negedge i_clk);
    endtask

    task automatic program_table();
        for (int i = 0; i < hrf_pkg::NUM_REPORTS; i++) begin
            write_reg(hrf_pkg::CFG_IDX_ENTRY_0 + 3'(i), cfg_table[i]);
        end
        write_reg(hrf_pkg::CFG_IDX_ENTRIES, {21'($urandom), cfg_count});
        cfg_valid <= 1'b0;
    endtask

    // Hold off the sender until every predicted result has drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_report_bytes.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic test_reset_table();
        send_message(16'd1, 1, 1'b1, 1'b0);
        send_message(16'd3, 3, 1'b1, 1'b0);
    endtask

    // Size below 3 still carries one payload byte; entry count 0 acts as 1
    task automatic test_tiny_entries();
        wait_idle();
        cfg_table[0] = 24'h000000;
        cfg_table[1] = 24'hFF0001;
        cfg_table[2] = 24'h120002;
        cfg_table[3] = 24'h130003;
        cfg_table[4] = 24'h140004;
        cfg_table[5] = 24'hFFFFFF;
        cfg_count = 3'd0;
        program_table();
        send_message(16'd3, 3, 1'b1, 1'b0);
    endtask

    task automatic test_entry_select();
        wait_idle();
        cfg_table[0] = 24'h100004;
        cfg_table[1] = 24'h200006;
        cfg_table[2] = 24'h300008;
        cfg_table[3] = 24'h40000A;
        cfg_table[4] = 24'h50000C;
        cfg_table[5] = 24'hFFFFFF;
        cfg_count = 3'd7;
        program_table();
        send_message(16'd5, 5, 1'b1, 1'b0);
        send_message(16'hFFFF, 3, 1'b1, 1'b0);
    endtask

    task automatic test_length_corners();
        send_message(16'd2, 4, 1'b1, 1'b0);
        send_message(16'd0, 1, 1'b1, 1'b0);
        send_message(16'd0, 1, 1'b0, 1'b0);
        // length is only looked at when a report starts
        send_message(16'd4, 3, 1'b1, 1'b1);
    endtask

    task automatic run_random_phase(input int in_pct, input int out_pct, input int shape,
                                    input int quota);
        int size_acc;
        int kind;
        int len;
        int goal;
        wait_idle();
        size_acc = $urandom_range(0, 5);
        for (int i = 0; i < hrf_pkg::NUM_REPORTS; i++) begin
            if (shape == 1) cfg_table[i] = {8'($urandom), 16'($urandom_range(0, 3))};
            else if (shape == 2) cfg_table[i] = 24'($urandom);
            else begin
                cfg_table[i] = {8'($urandom), 16'(size_acc)};
                size_acc += $urandom_range(0, 6);
            end
        end
        cfg_count = 3'($urandom_range(0, 7));
        program_table();
        in_idle_pct = in_pct;
        out_stall_pct = out_pct;
        goal = bytes_sent + quota;
        while (bytes_sent < goal) begin
            kind = $urandom_range(99);
            if (kind < 80) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 25);
                send_message(16'(len), len, 1'b1, 1'b0);
            end else if (kind < 88) begin
                send_message(16'($urandom), $urandom_range(1, 8), 1'b1, 1'b0);
            end else if (kind < 94) begin
                len = $urandom_range(1, 6);
                send_message(16'(len), len + $urandom_range(1, 4), 1'b1, 1'b0);
            end else begin
                send_message(16'($urandom_range(0, 20)), $urandom_range(1, 6),
                             1'($urandom_range(1)), 1'b1);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < hrf_pkg::NUM_REPORTS; i++) rpt_table[i] = hrf_pkg::ENTRY_RESET;
        rpt_count = 3'd1;
        bytes_taken = '0;
        payload_due = '0;
        msg_started = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        out_stall_pct = 35;
        test_reset_table();
        test_tiny_entries();
        test_entry_select();
        test_length_corners();
        run_random_phase(0, 0, 0, 80);
        run_random_phase(88, 0, 1, 80);
        run_random_phase(0, 88, 0, 80);
        run_random_phase(35, 35, 2, 80);
        run_random_phase(0, 0, 0, 80);
        wait_idle();
        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: hid_report_fragmenter.f
+incdir+sv
sv/hrf_pkg.sv
sv/hid_report_fragmenter.sv
tb/testbench.sv
